/* src/bba_pkg.sv */
// Shared types, constants and the helper function of the bitmap block allocator.
package bba_pkg;

  localparam int WORD_BITS     = 32;
  localparam int MAP_WORDS     = 64;
  localparam int ADDR_W        = $clog2(MAP_WORDS);
  localparam int UNIT_BYTES    = 32;
  localparam int UNIT_SHIFT    = $clog2(UNIT_BYTES);
  localparam int HEADER_BYTES  = 2;
  localparam int MAX_RUN_UNITS = 64;
  localparam int NEED_W        = 7;
  localparam int UNIT_W        = 11;
  localparam int USED_W        = 12;
  localparam int BYTES_W       = 17;
  localparam logic [BYTES_W-1:0] BYTES_MAX = '1;

  typedef enum logic [1:0] {
    STAT_ALLOCATED = 2'd0,
    STAT_FREED     = 2'd1,
    STAT_TOO_LARGE = 2'd2,
    STAT_NO_SPACE  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    FSM_IDLE,
    FSM_DECODE,
    FSM_ALLOC_FIRST,
    FSM_ALLOC_EVAL,
    FSM_MARK_A,
    FSM_MARK_B,
    FSM_FREE_RD,
    FSM_FREE_MOD,
    FSM_UPDATE,
    FSM_RESULT
  } fsm_t;

  typedef struct packed {
    logic in_hit;
    logic [4:0] in_pos;
    logic [5:0] head;
    logic [5:0] tail;
  } word_eval_t;

  typedef struct packed {
    logic alloc;
    logic release_run;
    logic [NEED_W-1:0] need;
    logic [15:0] req;
    logic [NEED_W-1:0] cleared;
  } stat_upd_t;

  // Bits of unit positions lo..hi-1, positions counted from the most significant bit.
  function automatic logic [WORD_BITS-1:0] run_mask(input logic [5:0] lo, input logic [5:0] hi);
    logic [WORD_BITS-1:0] m;
    m = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      m[i] = (6'(WORD_BITS - 1 - i) >= lo) && (6'(WORD_BITS - 1 - i) < hi);
    end
    return m;
  endfunction

endpackage

/* src/bba_map_mem.sv */
// Bitmap memory with registered read and per-entry valid bits for reset.
module bba_map_mem (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 rd_en,
  input  logic [bba_pkg::ADDR_W-1:0]           rd_addr,
  output logic [bba_pkg::WORD_BITS-1:0]        rd_data,
  input  logic                                 wr_en,
  input  logic [bba_pkg::ADDR_W-1:0]           wr_addr,
  input  logic [bba_pkg::WORD_BITS-1:0]        wr_data
);

  logic [bba_pkg::WORD_BITS-1:0] mem [bba_pkg::MAP_WORDS];
  logic [bba_pkg::MAP_WORDS-1:0] valid;
  logic [bba_pkg::WORD_BITS-1:0] rd_q;
  logic                          rd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid ? rd_q : '0;

endmodule

/* src/bba_word_eval.sv */
// First-fit search inside one bitmap word and free-run counts at the word boundary.
module bba_word_eval (
  input  logic [bba_pkg::WORD_BITS-1:0] cur,
  input  logic [bba_pkg::WORD_BITS-1:0] nxt,
  input  logic [bba_pkg::NEED_W-1:0]    need,
  output bba_pkg::word_eval_t           res
);

  logic [bba_pkg::WORD_BITS-1:0] fits;
  logic [6:0] hi_ext;

  always_comb begin
    for (int p = 0; p < bba_pkg::WORD_BITS; p++) begin
      hi_ext  = 7'(p) + need;
      fits[p] = (hi_ext <= 7'(bba_pkg::WORD_BITS)) &&
                ((cur & bba_pkg::run_mask(6'(p), hi_ext[5:0])) == '0);
    end
  end

  always_comb begin
    res = '0;
    for (int p = bba_pkg::WORD_BITS - 1; p >= 0; p--) begin
      if (fits[p]) begin
        res.in_hit = 1'b1;
        res.in_pos = 5'(p);
      end
    end
    res.head = 6'(bba_pkg::WORD_BITS);
    for (int i = bba_pkg::WORD_BITS - 1; i >= 0; i--) begin
      if (cur[i]) begin
        res.head = 6'(i);
      end
    end
    res.tail = 6'(bba_pkg::WORD_BITS);
    for (int i = 0; i < bba_pkg::WORD_BITS; i++) begin
      if (nxt[i]) begin
        res.tail = 6'(bba_pkg::WORD_BITS - 1 - i);
      end
    end
  end

endmodule

/* src/bba_stats.sv */
// Usage counters with saturating byte totals and peak tracking.
module bba_stats (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         upd_en,
  input  bba_pkg::stat_upd_t           upd,
  output logic [bba_pkg::USED_W-1:0]   used_count,
  output logic [bba_pkg::BYTES_W-1:0]  user_total,
  output logic [bba_pkg::BYTES_W-1:0]  user_peak,
  output logic [bba_pkg::BYTES_W-1:0]  pool_total,
  output logic [bba_pkg::BYTES_W-1:0]  pool_peak
);

  logic [bba_pkg::BYTES_W-1:0] run_bytes;
  logic [bba_pkg::BYTES_W:0]   pool_sum;
  logic [bba_pkg::BYTES_W:0]   user_sum;
  logic [bba_pkg::BYTES_W-1:0] pool_next;
  logic [bba_pkg::BYTES_W-1:0] user_next;

  assign run_bytes = bba_pkg::BYTES_W'(upd.need) << bba_pkg::UNIT_SHIFT;
  assign pool_sum  = {1'b0, pool_total} + {1'b0, run_bytes};
  assign user_sum  = {1'b0, user_total} + 18'(upd.req);

  always_comb begin
    pool_next = pool_total;
    user_next = user_total;
    if (upd.alloc) begin
      pool_next = pool_sum[bba_pkg::BYTES_W] ? bba_pkg::BYTES_MAX : pool_sum[bba_pkg::BYTES_W-1:0];
      user_next = user_sum[bba_pkg::BYTES_W] ? bba_pkg::BYTES_MAX : user_sum[bba_pkg::BYTES_W-1:0];
    end else if (upd.release_run) begin
      pool_next = (run_bytes > pool_total) ? '0 : pool_total - run_bytes;
      user_next = (17'(upd.req) > user_total) ? '0 : user_total - 17'(upd.req);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used_count <= '0;
      user_total <= '0;
      user_peak  <= '0;
      pool_total <= '0;
      pool_peak  <= '0;
    end else if (upd_en) begin
      pool_total <= pool_next;
      user_total <= user_next;
      if (upd.alloc) begin
        used_count <= used_count + bba_pkg::USED_W'(upd.need);
        if (pool_next > pool_peak) begin
          pool_peak <= pool_next;
        end
        if (user_next > user_peak) begin
          user_peak <= user_next;
        end
      end else if (upd.release_run) begin
        used_count <= used_count - bba_pkg::USED_W'(upd.cleared);
      end
    end
  end

endmodule

/* src/bitmap_block_allocator.sv */
// Top level of the bitmap first-fit block allocator.
//
// Channel  Dir  Fields
// s_*      in   s_tuser: action; s_tdata: req_bytes, free_start
// m_*      out  m_tuser: status; m_tdata: start_unit, used_units, byte counters
//
// An allocation reads the bitmap one word per cycle: it decodes the request, scans words
// until a run fits, writes one or two words, updates the counters and gives the result.
// A free reads and rewrites each touched word (at most three words), then updates the counters.
// Reset clears the bitmap through per-word valid bits and zeroes the counters.
// A new word is taken while a result still waits; the result waits until m_tready.
module bitmap_block_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // req_bytes[15:0], free_start[26:16], zeros above
  input  logic        s_tuser,   // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // start_unit, used_units, cur_user_bytes, peak_user_bytes,
                                 // cur_pool_bytes, peak_pool_bytes, zeros above
  output logic [1:0]  m_tuser    // status
);

  bba_pkg::fsm_t state, state_next;

  logic                               act_q;
  logic [15:0]                        req_q;
  logic [bba_pkg::UNIT_W-1:0]         fstart_q;
  logic [bba_pkg::NEED_W-1:0]         need_q;
  logic [bba_pkg::ADDR_W-1:0]         w_q;
  logic [bba_pkg::ADDR_W-1:0]         fw_q;
  logic [bba_pkg::WORD_BITS-1:0]      cur_q, nxt_q, mask_a_q, mask_b_q;
  logic                               two_q;
  logic [bba_pkg::UNIT_W-1:0]         start_q;
  bba_pkg::status_t                   status_q;
  logic [bba_pkg::NEED_W-1:0]         cleared_q;

  logic [16:0]                        need_sum;
  logic [11:0]                        need_raw;
  logic                               too_large;
  logic [11:0]                        endm1;
  logic [bba_pkg::ADDR_W-1:0]         last_word;
  logic [5:0]                         free_lo, free_hi;
  logic [bba_pkg::WORD_BITS-1:0]      free_mask;
  logic [bba_pkg::WORD_BITS-1:0]      free_hit;

  logic                               rd_en, wr_en;
  logic [bba_pkg::ADDR_W-1:0]         rd_addr, wr_addr;
  logic [bba_pkg::WORD_BITS-1:0]      rd_data, wr_data;

  bba_pkg::word_eval_t                ev;
  logic                               w_last, cross_ok;
  logic [6:0]                         span;
  logic                               upd_en;
  bba_pkg::stat_upd_t                 upd;

  logic [bba_pkg::USED_W-1:0]         used_count;
  logic [bba_pkg::BYTES_W-1:0]        user_total, user_peak, pool_total, pool_peak;

  bba_map_mem u_mem (
    .clk, .rst, .rd_en, .rd_addr, .rd_data, .wr_en, .wr_addr, .wr_data
  );

  bba_word_eval u_eval (
    .cur(cur_q), .nxt(rd_data), .need(need_q), .res(ev)
  );

  bba_stats u_stats (
    .clk, .rst, .upd_en, .upd,
    .used_count, .user_total, .user_peak, .pool_total, .pool_peak
  );

  assign need_sum  = 17'(req_q) + 17'(bba_pkg::HEADER_BYTES + bba_pkg::UNIT_BYTES - 1);
  assign need_raw  = need_sum[16:bba_pkg::UNIT_SHIFT];
  assign too_large = need_raw > 12'(bba_pkg::MAX_RUN_UNITS);

  assign endm1     = 12'(fstart_q) + 12'(need_q) - 12'd1;
  assign last_word = endm1[11] ? bba_pkg::ADDR_W'(bba_pkg::MAP_WORDS - 1) : endm1[10:5];
  assign free_lo   = (fw_q == fstart_q[10:5]) ? {1'b0, fstart_q[4:0]} : 6'd0;
  assign free_hi   = (!endm1[11] && fw_q == endm1[10:5]) ? 6'(endm1[4:0]) + 6'd1
                                                         : 6'(bba_pkg::WORD_BITS);
  assign free_mask = bba_pkg::run_mask(free_lo, free_hi);
  assign free_hit  = rd_data & free_mask;

  assign w_last   = (w_q == bba_pkg::ADDR_W'(bba_pkg::MAP_WORDS - 1));
  assign span     = 7'(ev.head) + 7'(ev.tail);
  assign cross_ok = !w_last && (span >= need_q);

  assign upd.alloc       = (status_q == bba_pkg::STAT_ALLOCATED);
  assign upd.release_run = (status_q == bba_pkg::STAT_FREED);
  assign upd.need        = need_q;
  assign upd.req         = req_q;
  assign upd.cleared     = cleared_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bba_pkg::FSM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = w_q;
    wr_data    = cur_q | mask_a_q;
    upd_en     = 1'b0;
    case (state)
      bba_pkg::FSM_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = bba_pkg::FSM_DECODE;
        end
      end
      bba_pkg::FSM_DECODE: begin
        if (too_large) begin
          state_next = bba_pkg::FSM_RESULT;
        end else if (act_q) begin
          state_next = bba_pkg::FSM_FREE_RD;
        end else begin
          rd_en      = 1'b1;
          state_next = bba_pkg::FSM_ALLOC_FIRST;
        end
      end
      bba_pkg::FSM_ALLOC_FIRST: begin
        rd_en      = 1'b1;
        rd_addr    = w_q + 1'b1;
        state_next = bba_pkg::FSM_ALLOC_EVAL;
      end
      bba_pkg::FSM_ALLOC_EVAL: begin
        if (ev.in_hit && need_q <= 7'(bba_pkg::WORD_BITS)) begin
          state_next = bba_pkg::FSM_MARK_A;
        end else if (cross_ok) begin
          state_next = bba_pkg::FSM_MARK_A;
        end else if (w_last) begin
          state_next = bba_pkg::FSM_RESULT;
        end else if (w_q + 1'b1 != bba_pkg::ADDR_W'(bba_pkg::MAP_WORDS - 1)) begin
          rd_en   = 1'b1;
          rd_addr = w_q + 2'd2;
        end
      end
      bba_pkg::FSM_MARK_A: begin
        wr_en      = 1'b1;
        state_next = two_q ? bba_pkg::FSM_MARK_B : bba_pkg::FSM_UPDATE;
      end
      bba_pkg::FSM_MARK_B: begin
        wr_en      = 1'b1;
        wr_addr    = w_q + 1'b1;
        wr_data    = nxt_q | mask_b_q;
        state_next = bba_pkg::FSM_UPDATE;
      end
      bba_pkg::FSM_FREE_RD: begin
        rd_en      = 1'b1;
        rd_addr    = fw_q;
        state_next = bba_pkg::FSM_FREE_MOD;
      end
      bba_pkg::FSM_FREE_MOD: begin
        wr_en      = 1'b1;
        wr_addr    = fw_q;
        wr_data    = rd_data & ~free_mask;
        state_next = (fw_q == last_word) ? bba_pkg::FSM_UPDATE : bba_pkg::FSM_FREE_RD;
      end
      bba_pkg::FSM_UPDATE: begin
        upd_en     = 1'b1;
        state_next = bba_pkg::FSM_RESULT;
      end
      bba_pkg::FSM_RESULT: begin
        if (!m_tvalid || m_tready) begin
          state_next = bba_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_next = bba_pkg::FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      bba_pkg::FSM_IDLE: begin
        act_q    <= s_tuser;
        req_q    <= s_tdata[15:0];
        fstart_q <= s_tdata[26:16];
      end
      bba_pkg::FSM_DECODE: begin
        need_q    <= (need_raw == 12'd0) ? 7'd1 : need_raw[6:0];
        w_q       <= '0;
        fw_q      <= fstart_q[10:5];
        cleared_q <= '0;
        start_q   <= '0;
        two_q     <= 1'b0;
        if (too_large) begin
          status_q <= bba_pkg::STAT_TOO_LARGE;
        end else if (act_q) begin
          status_q <= bba_pkg::STAT_FREED;
        end else begin
          status_q <= bba_pkg::STAT_NO_SPACE;
        end
      end
      bba_pkg::FSM_ALLOC_FIRST: begin
        cur_q <= rd_data;
      end
      bba_pkg::FSM_ALLOC_EVAL: begin
        if (ev.in_hit && need_q <= 7'(bba_pkg::WORD_BITS)) begin
          status_q <= bba_pkg::STAT_ALLOCATED;
          start_q  <= {w_q, ev.in_pos};
          mask_a_q <= bba_pkg::run_mask({1'b0, ev.in_pos}, 6'({1'b0, ev.in_pos} + need_q));
        end else if (cross_ok) begin
          status_q <= bba_pkg::STAT_ALLOCATED;
          start_q  <= {w_q, 5'd0} + 11'(bba_pkg::WORD_BITS) - 11'(ev.head);
          mask_a_q <= bba_pkg::run_mask(6'(bba_pkg::WORD_BITS) - ev.head,
                                        6'(bba_pkg::WORD_BITS));
          mask_b_q <= bba_pkg::run_mask(6'd0, 6'(need_q - 7'(ev.head)));
          nxt_q    <= rd_data;
          two_q    <= 1'b1;
        end else if (!w_last) begin
          cur_q <= rd_data;
          w_q   <= w_q + 1'b1;
        end
      end
      bba_pkg::FSM_FREE_MOD: begin
        cleared_q <= cleared_q + 7'($countones(free_hit));
        fw_q      <= fw_q + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == bba_pkg::FSM_RESULT && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == bba_pkg::FSM_RESULT && (!m_tvalid || m_tready)) begin
      m_tuser <= status_q;
      m_tdata <= {5'd0, pool_peak, pool_total, user_peak, user_total, used_count,
                  (status_q == bba_pkg::STAT_ALLOCATED) ? start_q : 11'd0};
    end
  end

  mem_no_collision: assert property (@(posedge clk) disable iff (rst)
    !(rd_en && wr_en))
    else $error("bitmap read and write issued in the same cycle");

  free_within_run: assert property (@(posedge clk) disable iff (rst)
    state == bba_pkg::FSM_FREE_MOD |-> fw_q <= last_word)
    else $error("free walked past the last word of its run");

  second_word_marked: assert property (@(posedge clk) disable iff (rst)
    state == bba_pkg::FSM_MARK_B |-> mask_b_q != '0)
    else $error("boundary run marks nothing in the second word");

  alloc_from_eval: assert property (@(posedge clk) disable iff (rst)
    state == bba_pkg::FSM_MARK_A |-> $past(state) == bba_pkg::FSM_ALLOC_EVAL)
    else $error("marking entered without a scan hit");

endmodule

/* test/bitmap_block_allocator_chk.sv */
// Checker that predicts each allocator result and compares it with the output word.
`timescale 1ns / 100ps
module bitmap_block_allocator_chk (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [95:0] m_tdata,
  input  logic [1:0]  m_tuser,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    bba_pkg::status_t            status;
    logic [bba_pkg::UNIT_W-1:0]  start_unit;
    logic [bba_pkg::USED_W-1:0]  used_units;
    logic [bba_pkg::BYTES_W-1:0] cur_user;
    logic [bba_pkg::BYTES_W-1:0] peak_user;
    logic [bba_pkg::BYTES_W-1:0] cur_pool;
    logic [bba_pkg::BYTES_W-1:0] peak_pool;
  } alloc_result_t;

  logic [bba_pkg::WORD_BITS-1:0] bitmap [bba_pkg::MAP_WORDS];
  int unsigned units_used, user_bytes, user_high, pool_bytes, pool_high;
  alloc_result_t result_fifo [$];

  function automatic int unsigned lead_zeros(logic [31:0] w);
    int unsigned i;
    for (i = 0; i < 32; i++) if (w[31-i]) break;
    return i;
  endfunction

  function automatic int unsigned trail_zeros(logic [31:0] w);
    int unsigned i;
    for (i = 0; i < 32; i++) if (w[i]) break;
    return i;
  endfunction

  function automatic int first_fit(logic [31:0] w, int unsigned n);
    logic [31:0] m;
    for (int p = 0; p <= 32 - int'(n); p++) begin
      m = (n >= 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 1);
      m = m << (32 - n - p);
      if ((w & m) == 0) return p;
    end
    return -1;
  endfunction

  task automatic mark_units(int unsigned first, int unsigned n, bit set);
    int unsigned u;
    for (int unsigned i = 0; i < n; i++) begin
      u = first + i;
      if (u < bba_pkg::MAP_WORDS * bba_pkg::WORD_BITS) begin
        if (set && !bitmap[u/32][31-u%32]) begin
          bitmap[u/32][31-u%32] = 1'b1;
          units_used++;
        end else if (!set && bitmap[u/32][31-u%32]) begin
          bitmap[u/32][31-u%32] = 1'b0;
          units_used--;
        end
      end
    end
  endtask

  task automatic predict_request(logic act, logic [15:0] req, logic [10:0] fstart);
    int unsigned need, first, hd, tl;
    int p;
    bit found;
    alloc_result_t r;
    need = (req + bba_pkg::HEADER_BYTES + bba_pkg::UNIT_BYTES - 1) / bba_pkg::UNIT_BYTES;
    if (need == 0) need = 1;
    first = 0;
    found = 0;
    if (need > bba_pkg::MAX_RUN_UNITS) begin
      r.status = bba_pkg::STAT_TOO_LARGE;
    end else if (act) begin
      mark_units(fstart, need, 0);
      pool_bytes = (need * bba_pkg::UNIT_BYTES > pool_bytes) ? 0
                 : pool_bytes - need * bba_pkg::UNIT_BYTES;
      user_bytes = (req > user_bytes) ? 0 : user_bytes - req;
      r.status = bba_pkg::STAT_FREED;
    end else begin
      for (int unsigned w = 0; w < bba_pkg::MAP_WORDS && !found; w++) begin
        if (need <= 32) begin
          p = first_fit(bitmap[w], need);
          if (p >= 0) begin
            first = w * 32 + p;
            found = 1;
            break;
          end
        end
        if (w + 1 < bba_pkg::MAP_WORDS) begin
          hd = trail_zeros(bitmap[w]);
          tl = lead_zeros(bitmap[w+1]);
          if (hd + tl >= need) begin
            first = w * 32 + 32 - hd;
            found = 1;
            break;
          end
        end
      end
      if (found) begin
        mark_units(first, need, 1);
        pool_bytes = pool_bytes + need * bba_pkg::UNIT_BYTES;
        if (pool_bytes > bba_pkg::BYTES_MAX) pool_bytes = bba_pkg::BYTES_MAX;
        user_bytes = user_bytes + req;
        if (user_bytes > bba_pkg::BYTES_MAX) user_bytes = bba_pkg::BYTES_MAX;
        if (pool_bytes > pool_high) pool_high = pool_bytes;
        if (user_bytes > user_high) user_high = user_bytes;
        r.status = bba_pkg::STAT_ALLOCATED;
      end else begin
        first = 0;
        r.status = bba_pkg::STAT_NO_SPACE;
      end
    end
    r.start_unit = first[bba_pkg::UNIT_W-1:0];
    r.used_units = (units_used > 4095) ? 12'hFFF : units_used[bba_pkg::USED_W-1:0];
    r.cur_user   = user_bytes[bba_pkg::BYTES_W-1:0];
    r.peak_user  = user_high[bba_pkg::BYTES_W-1:0];
    r.cur_pool   = pool_bytes[bba_pkg::BYTES_W-1:0];
    r.peak_pool  = pool_high[bba_pkg::BYTES_W-1:0];
    result_fifo.push_back(r);
  endtask

  task automatic compare_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    alloc_result_t e;
    if (rst) begin
      foreach (bitmap[i]) bitmap[i] = '0;
      units_used = 0; user_bytes = 0; user_high = 0; pool_bytes = 0; pool_high = 0;
      result_fifo.delete();
      fail_count = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (result_fifo.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual status %0d",
                   $time, m_tuser);
          fail_count++;
        end else begin
          e = result_fifo.pop_front();
          compare_field("status", e.status, m_tuser);
          compare_field("start_unit", e.start_unit, m_tdata[10:0]);
          compare_field("used_units", e.used_units, m_tdata[22:11]);
          compare_field("cur_user_bytes", e.cur_user, m_tdata[39:23]);
          compare_field("peak_user_bytes", e.peak_user, m_tdata[56:40]);
          compare_field("cur_pool_bytes", e.cur_pool, m_tdata[73:57]);
          compare_field("peak_pool_bytes", e.peak_pool, m_tdata[90:74]);
          compare_field("pad bits", 0, m_tdata[95:91]);
        end
      end
      if (s_tvalid && s_tready) predict_request(s_tuser, s_tdata[15:0], s_tdata[26:16]);
    end
    pending = result_fifo.size();
  end

endmodule

/* test/bitmap_block_allocator_tb.sv */
// Testbench top that drives directed and random allocate and free words into the allocator.
`timescale 1ns / 100ps
module bitmap_block_allocator_tb;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  logic clk, rst, s_tvalid, s_tready, s_tuser, m_tvalid, m_tready;
  logic [31:0] s_tdata;
  logic [95:0] m_tdata;
  logic [1:0]  m_tuser;
  int fail_count, pending, send_idle_pct, recv_stall_pct, hold_off;
  longint cycles;
  logic [10:0] live_start [$];
  logic [15:0] live_size [$];

  bitmap_block_allocator i_dut (.*);

  bitmap_block_allocator_chk i_chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("bitmap_block_allocator_tb NOT OK");
        $finish;
      end
    end
  end

  // Receiver with random stalls and one long hold-off.
  initial begin
    m_tready = 0;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        hold_off--;
        m_tready <= 0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_word(logic act, logic [15:0] req, logic [10:0] fstart);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      @(negedge clk);
    end
    s_tvalid <= 1;
    s_tuser  <= act;
    s_tdata  <= {5'd0, fstart, req};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_request();
    int k, r;
    logic [15:0] sz;
    r = $urandom_range(99);
    if (r < 45 || live_start.size() == 0) begin
      sz = ($urandom_range(9) == 0) ? 16'($urandom_range(2100)) : 16'($urandom_range(200));
      send_word(ACT_ALLOC, sz, 11'($urandom));
      // Guessed start: the first fit prediction lives in the checker; freeing by size only.
      live_start.push_back(11'($urandom));
      live_size.push_back(sz);
    end else if (r < 85) begin
      k = $urandom_range(live_start.size() - 1);
      send_word(ACT_FREE, live_size[k], live_start[k]);
      live_start.delete(k);
      live_size.delete(k);
    end else begin
      send_word(1'($urandom), 16'($urandom), 11'($urandom));
    end
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    rst = 1; s_tvalid = 0; s_tdata = '0; s_tuser = 0;
    send_idle_pct = 0; recv_stall_pct = 0; hold_off = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 0;
    send_word(ACT_ALLOC, 16'd0, 11'd0);
    send_word(ACT_ALLOC, 16'd30, 11'h7FF);
    send_word(ACT_ALLOC, 16'd31, 11'd0);
    send_word(ACT_ALLOC, 16'd2046, 11'd0);
    send_word(ACT_ALLOC, 16'd2047, 11'd0);
    send_word(ACT_ALLOC, 16'hFFFF, 11'd0);
    send_word(ACT_FREE, 16'hFFFF, 11'd0);
    send_word(ACT_FREE, 16'd100, 11'd2);
    send_word(ACT_FREE, 16'd100, 11'd2);
    send_word(ACT_FREE, 16'd2046, 11'd2040);
    send_word(ACT_FREE, 16'd2046, 11'h7FF);
    for (int i = 0; i < 40; i++) send_word(ACT_ALLOC, 16'd2046, 11'd0);
    send_word(ACT_ALLOC, 16'd1000, 11'd0);
    send_word(ACT_FREE, 16'd2046, 11'd64);
    send_word(ACT_ALLOC, 16'd600, 11'd0);
    send_word(ACT_FREE, 16'd1022, 11'd200);
    send_word(ACT_ALLOC, 16'd500, 11'd0);
    for (int i = 0; i < 64; i++) send_word(ACT_FREE, 16'd2046, 11'(i * 32));
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 62 : (ph == 3) ? 31 : 0;
      recv_stall_pct = (ph == 2) ? 62 : (ph == 3) ? 31 : 0;
      if (ph == 0) hold_off = 3000;
      for (int i = 0; i < 340; i++) random_request();
      if (ph == 1) for (int i = 0; i < 64; i++) send_word(ACT_FREE, 16'd2046, 11'(i * 32));
    end
    recv_stall_pct = 0;
    drain();
    if (fail_count == 0) begin
      $display("bitmap_block_allocator_tb OK");
    end else begin
      $display("bitmap_block_allocator_tb NOT OK");
    end
    $finish;
  end

endmodule
